// File: rtl/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, codes and calendar functions for the calendar date adder.
// ----------------------------------------------------------------------------
package cda_pkg;

    localparam int KIND_W   = 3;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int AMT_W    = 16;
    localparam int STAT_W   = 2;
    localparam int REM_W    = 19;
    localparam int WIDE_W   = 26;
    localparam int OP_W     = 4;
    localparam int LEAP_W   = 16;

    // unit kinds
    localparam logic [KIND_W-1:0] KIND_DAYS       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WEEKS      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MONTHS     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_YEARS      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DECADES    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CENTURIES  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_MILLENNIA  = 3'd6;

    // result status
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

    // result source
    localparam logic SRC_INPUT = 1'b0;
    localparam logic SRC_WORK  = 1'b1;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
    localparam logic [OP_W-1:0] OP_DAY_INIT  = 4'd2;
    localparam logic [OP_W-1:0] OP_YEAR400   = 4'd3;
    localparam logic [OP_W-1:0] OP_YEAR1     = 4'd4;
    localparam logic [OP_W-1:0] OP_MON1_INIT = 4'd5;
    localparam logic [OP_W-1:0] OP_DMON_STEP = 4'd6;
    localparam logic [OP_W-1:0] OP_DAY_END   = 4'd7;
    localparam logic [OP_W-1:0] OP_MON_INIT  = 4'd8;
    localparam logic [OP_W-1:0] OP_M400      = 4'd9;
    localparam logic [OP_W-1:0] OP_M12       = 4'd10;
    localparam logic [OP_W-1:0] OP_M1        = 4'd11;
    localparam logic [OP_W-1:0] OP_YADD_MUL  = 4'd12;
    localparam logic [OP_W-1:0] OP_YADD_END  = 4'd13;

    // calendar constants
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FEB_LEAP = 5'd29;
    localparam logic [DAY_W-1:0]   DAY_FEB_NORM = 5'd28;
    localparam int YEARS_CYCLE  = 400;
    localparam int DAYS_CYCLE   = 146097;
    localparam int MONTHS_CYCLE = 4800;
    localparam int MONTHS_YEAR  = 12;
    localparam logic [8:0] DAYS_YEAR_NORM = 9'd365;
    localparam logic [8:0] DAYS_YEAR_LEAP = 9'd366;

    // divisibility by 25 through the inverse of 25 modulo 2^16
    localparam logic [LEAP_W-1:0] INV25     = 16'd23593;
    localparam logic [LEAP_W-1:0] DIV25_LIM = 16'd2621;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              out_load;
        logic              res_src;
        logic [STAT_W-1:0] res_status;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              valid_date;
        logic              yy_over;
        logic              rem_gt_cycle;
        logic              rem_gt_year;
        logic              rem_gt_month;
        logic              cnt_ge_cycle;
        logic              cnt_ge_year;
        logic              cnt_zero;
        logic              wide_over;
        logic              out_free;
    } t_stat;

    function automatic logic leap_year(input logic [LEAP_W-1:0] y);
        logic [LEAP_W-1:0] prod;
        logic              div25;
        prod  = y * INV25;
        div25 = (prod <= DIV25_LIM);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = leap ? DAY_FEB_LEAP : DAY_FEB_NORM;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [9:0] kind_mult(input logic [KIND_W-1:0] k);
        logic [9:0] mul;
        unique case (k)
            KIND_YEARS:      mul = 10'd1;
            KIND_DECADES:    mul = 10'd10;
            KIND_CENTURIES:  mul = 10'd100;
            KIND_MILLENNIA:  mul = 10'd1000;
            default:         mul = 10'd0;
        endcase
        return mul;
    endfunction

endpackage

// File: rtl/cda_ctrl.sv
// ----------------------------------------------------------------------------
// cda_ctrl
// Sequencer for the date adder: validity check, year and month stepping
// loops and the hand-off of the finished word to the output register.
// ----------------------------------------------------------------------------
module cda_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cda_pkg::t_stat i_stat,
    output cda_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_YEARS  = 3'd2;
    localparam logic [2:0] S_DMON   = 3'd3;
    localparam logic [2:0] S_MONTHS = 3'd4;
    localparam logic [2:0] S_YFIN   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]                   r_state, n_state;
    logic                         r_src, n_src;
    logic [cda_pkg::STAT_W-1:0]   r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_src   <= cda_pkg::SRC_INPUT;
            r_res   <= cda_pkg::STAT_OK;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_src            = r_src;
        n_res            = r_res;
        o_in_ready       = 1'b0;
        o_cmd.op         = cda_pkg::OP_NONE;
        o_cmd.out_load   = 1'b0;
        o_cmd.res_src    = r_src;
        o_cmd.res_status = r_res;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = cda_pkg::OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.valid_date) begin
                    n_src   = cda_pkg::SRC_INPUT;
                    n_res   = cda_pkg::STAT_INVALID;
                    n_state = S_DONE;
                end else begin
                    case (i_stat.kind) inside
                        cda_pkg::KIND_DAYS, cda_pkg::KIND_WEEKS: begin
                            o_cmd.op = cda_pkg::OP_DAY_INIT;
                            n_state  = S_YEARS;
                        end
                        cda_pkg::KIND_MONTHS: begin
                            o_cmd.op = cda_pkg::OP_MON_INIT;
                            n_state  = S_MONTHS;
                        end
                        cda_pkg::KIND_YEARS, cda_pkg::KIND_DECADES,
                        cda_pkg::KIND_CENTURIES, cda_pkg::KIND_MILLENNIA: begin
                            o_cmd.op = cda_pkg::OP_YADD_MUL;
                            n_state  = S_YFIN;
                        end
                        default: begin
                            n_src   = cda_pkg::SRC_INPUT;
                            n_res   = cda_pkg::STAT_OK;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_YEARS: begin
                if (i_stat.yy_over) begin
                    n_src   = cda_pkg::SRC_INPUT;
                    n_res   = cda_pkg::STAT_OVERFLOW;
                    n_state = S_DONE;
                end else if (i_stat.rem_gt_cycle) begin
                    o_cmd.op = cda_pkg::OP_YEAR400;
                end else if (i_stat.rem_gt_year) begin
                    o_cmd.op = cda_pkg::OP_YEAR1;
                end else begin
                    o_cmd.op = cda_pkg::OP_MON1_INIT;
                    n_state  = S_DMON;
                end
            end
            S_DMON: begin
                if (i_stat.rem_gt_month) begin
                    o_cmd.op = cda_pkg::OP_DMON_STEP;
                end else begin
                    o_cmd.op = cda_pkg::OP_DAY_END;
                    n_src    = cda_pkg::SRC_WORK;
                    n_res    = cda_pkg::STAT_OK;
                    n_state  = S_DONE;
                end
            end
            S_MONTHS: begin
                if (i_stat.yy_over) begin
                    n_src   = cda_pkg::SRC_INPUT;
                    n_res   = cda_pkg::STAT_OVERFLOW;
                    n_state = S_DONE;
                end else if (i_stat.cnt_ge_cycle) begin
                    o_cmd.op = cda_pkg::OP_M400;
                end else if (i_stat.cnt_ge_year) begin
                    o_cmd.op = cda_pkg::OP_M12;
                end else if (!i_stat.cnt_zero) begin
                    o_cmd.op = cda_pkg::OP_M1;
                end else begin
                    n_src   = cda_pkg::SRC_WORK;
                    n_res   = cda_pkg::STAT_OK;
                    n_state = S_DONE;
                end
            end
            S_YFIN: begin
                n_state = S_DONE;
                if (i_stat.wide_over) begin
                    n_src = cda_pkg::SRC_INPUT;
                    n_res = cda_pkg::STAT_OVERFLOW;
                end else begin
                    o_cmd.op = cda_pkg::OP_YADD_END;
                    n_src    = cda_pkg::SRC_WORK;
                    n_res    = cda_pkg::STAT_OK;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/cda_dp.sv
// ----------------------------------------------------------------------------
// cda_dp
// Datapath for the date adder: input word, working date, remaining day and
// month counts, year product and the output register.
// ----------------------------------------------------------------------------
module cda_dp #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [cda_pkg::KIND_W-1:0]      i_kind,
    input  logic [cda_pkg::YEAR_W-1:0]      i_year,
    input  logic [cda_pkg::MONTH_W-1:0]     i_month,
    input  logic [cda_pkg::DAY_W-1:0]       i_day,
    input  logic [cda_pkg::AMT_W-1:0]       i_amount,
    input  cda_pkg::t_cmd                   i_cmd,
    output cda_pkg::t_stat                  o_stat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [cda_pkg::YEAR_W-1:0]      o_res_year,
    output logic [cda_pkg::MONTH_W-1:0]     o_res_month,
    output logic [cda_pkg::DAY_W-1:0]       o_res_day,
    output logic [cda_pkg::STAT_W-1:0]      o_status
);

    localparam int YW = $clog2(MAX_YEAR + cda_pkg::YEARS_CYCLE + 2);
    localparam int RW = cda_pkg::REM_W;
    localparam int WW = cda_pkg::WIDE_W;

    // input word
    logic [cda_pkg::KIND_W-1:0]  r_kind;
    logic [cda_pkg::YEAR_W-1:0]  r_y0;
    logic [cda_pkg::MONTH_W-1:0] r_m0;
    logic [cda_pkg::DAY_W-1:0]   r_d0;
    logic [cda_pkg::AMT_W-1:0]   r_amt;

    // working date
    logic [YW-1:0]               r_yy;
    logic [cda_pkg::MONTH_W-1:0] r_mm;
    logic [cda_pkg::DAY_W-1:0]   r_dd;
    logic [RW-1:0]               r_rem;
    logic [cda_pkg::AMT_W-1:0]   r_cnt;
    logic [WW-1:0]               r_wide;

    // output register
    logic                        r_out_valid;
    logic [cda_pkg::YEAR_W-1:0]  r_res_year;
    logic [cda_pkg::MONTH_W-1:0] r_res_month;
    logic [cda_pkg::DAY_W-1:0]   r_res_day;
    logic [cda_pkg::STAT_W-1:0]  r_status;

    logic                        leap_y0;
    logic                        leap_wk;
    logic [cda_pkg::LEAP_W-1:0]  wk_year;
    logic [YW-1:0]               yy_inc;
    logic [8:0]                  year_len;
    logic [cda_pkg::DAY_W-1:0]   mon_len;
    logic [cda_pkg::MONTH_W-1:0] mm_next;
    logic [cda_pkg::DAY_W-1:0]   mon_len_next;
    logic [cda_pkg::DAY_W-1:0]   feb_len;
    logic [RW-1:0]               day_scaled;
    logic [RW-1:0]               rem_init;
    logic [WW-1:0]               wide_prod;
    logic                        cnt_ge_year;
    logic                        out_free;

    assign leap_y0     = cda_pkg::leap_year(cda_pkg::LEAP_W'(r_y0));
    assign yy_inc      = r_yy + YW'(1);
    assign cnt_ge_year = (r_cnt >= cda_pkg::AMT_W'(cda_pkg::MONTHS_YEAR));

    // year whose leap flag the current step needs
    always_comb begin
        if (r_kind == cda_pkg::KIND_MONTHS) begin
            if (cnt_ge_year) begin
                wk_year = (r_mm == cda_pkg::MONTH_JAN) ? cda_pkg::LEAP_W'(r_yy)
                                                       : cda_pkg::LEAP_W'(yy_inc);
            end else begin
                wk_year = (r_mm == cda_pkg::MONTH_DEC) ? cda_pkg::LEAP_W'(yy_inc)
                                                       : cda_pkg::LEAP_W'(r_yy);
            end
        end else if (r_kind inside {cda_pkg::KIND_YEARS, cda_pkg::KIND_DECADES,
                                    cda_pkg::KIND_CENTURIES, cda_pkg::KIND_MILLENNIA}) begin
            wk_year = cda_pkg::LEAP_W'(r_wide);
        end else begin
            wk_year = cda_pkg::LEAP_W'(r_yy);
        end
    end

    assign leap_wk      = cda_pkg::leap_year(wk_year);
    assign year_len     = leap_wk ? cda_pkg::DAYS_YEAR_LEAP : cda_pkg::DAYS_YEAR_NORM;
    assign mon_len      = cda_pkg::month_days(r_mm, leap_wk);
    assign mm_next      = (r_mm == cda_pkg::MONTH_DEC) ? cda_pkg::MONTH_JAN
                                                       : r_mm + cda_pkg::MONTH_W'(1);
    assign mon_len_next = cda_pkg::month_days(mm_next, leap_wk);
    assign feb_len      = leap_wk ? cda_pkg::DAY_FEB_LEAP : cda_pkg::DAY_FEB_NORM;

    assign day_scaled = (r_kind == cda_pkg::KIND_WEEKS) ? ({r_amt, 3'b000} - RW'(r_amt))
                                                        : RW'(r_amt);
    assign rem_init   = RW'(r_d0) + RW'(cda_pkg::days_before(r_m0))
                      + RW'((r_m0 > cda_pkg::MONTH_FEB) && leap_y0) + day_scaled;
    assign wide_prod  = WW'(r_amt) * WW'(cda_pkg::kind_mult(r_kind));

    assign out_free = !r_out_valid || i_out_ready;

    // status to the controller
    always_comb begin
        o_stat.kind         = r_kind;
        o_stat.valid_date   = (r_y0 != '0)
                           && (cda_pkg::LEAP_W'(r_y0) <= cda_pkg::LEAP_W'(MAX_YEAR))
                           && (r_m0 >= cda_pkg::MONTH_JAN) && (r_m0 <= cda_pkg::MONTH_DEC)
                           && (r_d0 != '0)
                           && (r_d0 <= cda_pkg::month_days(r_m0, leap_y0));
        o_stat.yy_over      = (r_yy > YW'(MAX_YEAR));
        o_stat.rem_gt_cycle = (r_rem > RW'(cda_pkg::DAYS_CYCLE));
        o_stat.rem_gt_year  = (r_rem > RW'(year_len));
        o_stat.rem_gt_month = (r_rem > RW'(mon_len));
        o_stat.cnt_ge_cycle = (r_cnt >= cda_pkg::AMT_W'(cda_pkg::MONTHS_CYCLE));
        o_stat.cnt_ge_year  = cnt_ge_year;
        o_stat.cnt_zero     = (r_cnt == '0);
        o_stat.wide_over    = (r_wide > WW'(MAX_YEAR));
        o_stat.out_free     = out_free;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            cda_pkg::OP_LOAD: begin
                r_kind <= i_kind;
                r_y0   <= i_year;
                r_m0   <= i_month;
                r_d0   <= i_day;
                r_amt  <= i_amount;
            end
            cda_pkg::OP_DAY_INIT: begin
                r_yy  <= YW'(r_y0);
                r_rem <= rem_init;
            end
            cda_pkg::OP_YEAR400: begin
                r_rem <= r_rem - RW'(cda_pkg::DAYS_CYCLE);
                r_yy  <= r_yy + YW'(cda_pkg::YEARS_CYCLE);
            end
            cda_pkg::OP_YEAR1: begin
                r_rem <= r_rem - RW'(year_len);
                r_yy  <= yy_inc;
            end
            cda_pkg::OP_MON1_INIT: begin
                r_mm <= cda_pkg::MONTH_JAN;
            end
            cda_pkg::OP_DMON_STEP: begin
                r_rem <= r_rem - RW'(mon_len);
                r_mm  <= r_mm + cda_pkg::MONTH_W'(1);
            end
            cda_pkg::OP_DAY_END: begin
                r_dd <= r_rem[cda_pkg::DAY_W-1:0];
            end
            cda_pkg::OP_MON_INIT: begin
                r_yy  <= YW'(r_y0);
                r_mm  <= r_m0;
                r_dd  <= r_d0;
                r_cnt <= r_amt;
            end
            cda_pkg::OP_M400: begin
                if (r_dd > cda_pkg::DAY_FEB_NORM) begin
                    r_dd <= cda_pkg::DAY_FEB_NORM;
                end
                r_yy  <= r_yy + YW'(cda_pkg::YEARS_CYCLE);
                r_cnt <= r_cnt - cda_pkg::AMT_W'(cda_pkg::MONTHS_CYCLE);
            end
            cda_pkg::OP_M12: begin
                if (r_dd > feb_len) begin
                    r_dd <= feb_len;
                end
                r_yy  <= yy_inc;
                r_cnt <= r_cnt - cda_pkg::AMT_W'(cda_pkg::MONTHS_YEAR);
            end
            cda_pkg::OP_M1: begin
                r_mm <= mm_next;
                if (r_mm == cda_pkg::MONTH_DEC) begin
                    r_yy <= yy_inc;
                end
                if (r_dd > mon_len_next) begin
                    r_dd <= mon_len_next;
                end
                r_cnt <= r_cnt - cda_pkg::AMT_W'(1);
            end
            cda_pkg::OP_YADD_MUL: begin
                r_wide <= wide_prod + WW'(r_y0);
            end
            cda_pkg::OP_YADD_END: begin
                r_yy <= YW'(r_wide);
                r_mm <= r_m0;
                if ((r_m0 == cda_pkg::MONTH_FEB) && (r_d0 == cda_pkg::DAY_FEB_LEAP)
                    && !leap_wk) begin
                    r_dd <= cda_pkg::DAY_FEB_NORM;
                end else begin
                    r_dd <= r_d0;
                end
            end
            default: begin
            end
        endcase
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status <= i_cmd.res_status;
            if (i_cmd.res_src == cda_pkg::SRC_WORK) begin
                r_res_year  <= cda_pkg::YEAR_W'(r_yy);
                r_res_month <= r_mm;
                r_res_day   <= r_dd;
            end else begin
                r_res_year  <= r_y0;
                r_res_month <= r_m0;
                r_res_day   <= r_d0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res_year  = r_res_year;
    assign o_res_month = r_res_month;
    assign o_res_day   = r_res_day;
    assign o_status    = r_status;

endmodule

// File: rtl/calendar_date_adder.sv
// ----------------------------------------------------------------------------
// calendar_date_adder
// Adds days, weeks, months, years, decades, centuries or millennia to a
// Gregorian date, with month clamping and leap-year handling.
// ----------------------------------------------------------------------------
// One word is worked on at a time; the input side is ready again once the
// result sits in the output register, so a new word can enter while the
// previous result still waits. From input accept to output load, a bad date
// or an unused kind goes straight from the check to the output, a year-type
// add takes a multiply and a final step, and month and day adds run their
// step loops. Day and week adds step once per 146097-day stride of 400
// years while more than that remains, once per year and once per month;
// month adds step once per 400-year stride, once per whole year and once per
// leftover month. A year overflow ends the stepping at the step that passes
// MAX_YEAR. A result still waiting in the output register holds the load
// back. Each step updates the single working date in the datapath. An
// invalid input date or a result year above MAX_YEAR returns the input date
// with a nonzero status.
module calendar_date_adder #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [cda_pkg::KIND_W-1:0]      i_kind,
    input  logic [cda_pkg::YEAR_W-1:0]      i_year,
    input  logic [cda_pkg::MONTH_W-1:0]     i_month,
    input  logic [cda_pkg::DAY_W-1:0]       i_day,
    input  logic [cda_pkg::AMT_W-1:0]       i_amount,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [cda_pkg::YEAR_W-1:0]      o_res_year,
    output logic [cda_pkg::MONTH_W-1:0]     o_res_month,
    output logic [cda_pkg::DAY_W-1:0]       o_res_day,
    output logic [cda_pkg::STAT_W-1:0]      o_status
);

    cda_pkg::t_cmd  cmd;
    cda_pkg::t_stat stat;

    cda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cda_dp #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kind      (i_kind),
        .i_year      (i_year),
        .i_month     (i_month),
        .i_day       (i_day),
        .i_amount    (i_amount),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res_year  (o_res_year),
        .o_res_month (o_res_month),
        .o_res_day   (o_res_day),
        .o_status    (o_status)
    );

endmodule
